// File: src/tag_translation_slot_table_top_macros.svh
// Assertion macros for the tag translation slot table.
`ifndef TAG_TRANSLATION_SLOT_TABLE_TOP_MACROS_SVH
`define TAG_TRANSLATION_SLOT_TABLE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tts: same-cycle check failed");
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tts: next-cycle check failed");
`else
`define TTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/tts_pkg.sv
// Shared constants, codes and control types for the tag translation slot table.
`timescale 1ns / 1ps
`default_nettype none
package tts_pkg;
	localparam int ROWS       = 64;
	localparam int ROW_W      = $clog2(ROWS);
	localparam int CNT_W      = ROW_W + 1;
	localparam int CFG_W      = 7;
	localparam int WORD_W     = 32;
	localparam int ROWS_RESET = 64;
	localparam int GRP        = 8;
	localparam int GRPS       = ROWS / GRP;
	localparam int GRP_CNT_W  = $clog2(GRP + 1);

	localparam logic [1:0] KIND_INS_ADDR = 2'd0;
	localparam logic [1:0] KIND_TAKE_IDX = 2'd1;
	localparam logic [1:0] KIND_INS_PAIR = 2'd2;
	localparam logic [1:0] KIND_TAKE_VAL = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_MISS  = 2'd3;

	typedef struct packed {
		logic capture;
		logic find;
		logic take_rd;
		logic take_wr;
		logic scan;
		logic count;
		logic load;
	} tts_cmd_t;

	typedef struct packed {
		logic scan_hit;
		logic scan_miss;
		logic out_valid;
	} tts_sts_t;
endpackage
`default_nettype wire

// File: src/tts_ctrl.sv
// Sequencer for the tag translation slot table: one operation at a time.
`timescale 1ns / 1ps
`default_nettype none
module tts_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       kind,
	input  wire logic             out_ready,
	input  wire tts_pkg::tts_sts_t sts,
	output tts_pkg::tts_cmd_t     cmd
);
	import tts_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_FIND = 7'b0000010,
		S_TRD  = 7'b0000100,
		S_TWR  = 7'b0001000,
		S_SCAN = 7'b0010000,
		S_CNT  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	assign out_free = !sts.out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (kind)
						KIND_TAKE_IDX: state_d = S_TRD;
						KIND_TAKE_VAL: state_d = S_SCAN;
						default:       state_d = S_FIND;
					endcase
				end
			end
			S_FIND: state_d = S_CNT;
			S_TRD:  state_d = S_TWR;
			S_TWR:  state_d = S_CNT;
			S_SCAN: begin
				if (sts.scan_hit || sts.scan_miss) state_d = S_CNT;
			end
			S_CNT:  state_d = S_DONE;
			S_DONE: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.find    = (state_q == S_FIND);
		cmd.take_rd = (state_q == S_TRD);
		cmd.take_wr = (state_q == S_TWR);
		cmd.scan    = (state_q == S_SCAN);
		cmd.count   = (state_q == S_CNT);
		cmd.load    = (state_q == S_DONE) && out_free;
	end
endmodule
`default_nettype wire

// File: src/tts_dpath.sv
// Datapath: word memories, valid marks, row mask, search, count and result registers.
`timescale 1ns / 1ps
`default_nettype none
module tts_dpath (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire tts_pkg::tts_cmd_t          cmd,
	output tts_pkg::tts_sts_t               sts,
	input  wire logic                       cfg_we,
	input  wire logic [tts_pkg::CFG_W-1:0]  cfg_wdata,
	input  wire logic [1:0]                 kind,
	input  wire logic [tts_pkg::WORD_W-1:0] value_word,
	input  wire logic [tts_pkg::WORD_W-1:0] first_word,
	input  wire logic [tts_pkg::ROW_W-1:0]  slot,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output logic [tts_pkg::ROW_W-1:0]       row_out,
	output logic [tts_pkg::WORD_W-1:0]      data_out,
	output logic [1:0]                      status,
	output logic [tts_pkg::CNT_W-1:0]       occupied_count
);
	import tts_pkg::*;

	logic [WORD_W-1:0] first_mem  [ROWS];
	logic [WORD_W-1:0] second_mem [ROWS];
	logic [WORD_W-1:0] f_rd_q, s_rd_q;

	logic [ROWS-1:0]   fv_q, sv_q, mask_q;
	logic [1:0]        kind_q;
	logic [WORD_W-1:0] val_q, fw_q;
	logic [ROW_W-1:0]  slot_q;

	logic [ROW_W:0]    ctr_q;
	logic              rd_ok_s1;
	logic [ROW_W-1:0]  row_s1;

	logic [ROWS-1:0]   free_vec;
	logic              free_any;
	logic [ROW_W-1:0]  free_idx;
	logic              is_pair;
	logic [ROW_W-1:0]  raddr;
	logic              issue;
	logic              hit;
	logic              take_ok;

	logic [ROW_W-1:0]  res_row_q;
	logic [WORD_W-1:0] res_data_q;
	logic [1:0]        res_status_q;

	logic [GRP_CNT_W-1:0] part_s1 [GRPS];
	logic [GRP_CNT_W-1:0] part_d  [GRPS];
	logic [CNT_W-1:0]     cnt_sum;
	logic [ROWS-1:0]      occ_vec;
	logic                 out_valid_q;

	assign is_pair  = (kind_q == KIND_INS_PAIR);
	assign free_vec = (is_pair ? (~sv_q & ~fv_q) : ~sv_q) & mask_q;
	assign free_any = |free_vec;

	always_comb begin
		free_idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (free_vec[i]) free_idx = ROW_W'(i);
		end
	end

	assign raddr   = cmd.scan ? ctr_q[ROW_W-1:0] : slot_q;
	assign issue   = !ctr_q[ROW_W] && mask_q[ctr_q[ROW_W-1:0]];
	assign hit     = cmd.scan && rd_ok_s1 && sv_q[row_s1] && (s_rd_q == val_q);
	assign take_ok = mask_q[slot_q] && sv_q[slot_q];

	assign sts.scan_hit  = hit;
	assign sts.scan_miss = cmd.scan && !issue && !rd_ok_s1;
	assign sts.out_valid = out_valid_q;

	// word memories, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.find && free_any) begin
			second_mem[free_idx] <= val_q;
		end
		s_rd_q <= second_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.find && free_any && is_pair) begin
			first_mem[free_idx] <= fw_q;
		end
		f_rd_q <= first_mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			val_q  <= value_word;
			fw_q   <= first_word;
			slot_q <= slot;
		end
		row_s1 <= ctr_q[ROW_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q    <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			rd_ok_s1 <= cmd.scan && issue;
			if (cmd.capture) begin
				ctr_q <= '0;
			end else if (cmd.scan) begin
				ctr_q <= ctr_q + (ROW_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ROWS; i++) begin
				mask_q[i] <= (i < ROWS_RESET);
			end
		end else if (cfg_we) begin
			for (int i = 0; i < ROWS; i++) begin
				mask_q[i] <= (CFG_W'(i) < cfg_wdata);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_q <= '0;
			sv_q <= '0;
		end else begin
			if (cmd.find && free_any) begin
				sv_q[free_idx] <= 1'b1;
				if (is_pair) fv_q[free_idx] <= 1'b1;
			end
			if (cmd.take_wr && take_ok) begin
				sv_q[slot_q] <= 1'b0;
			end
			if (hit) begin
				sv_q[row_s1] <= 1'b0;
				fv_q[row_s1] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.find) begin
			res_row_q    <= free_any ? free_idx : '0;
			res_data_q   <= '0;
			res_status_q <= free_any ? ST_OK : ST_FULL;
		end else if (cmd.take_wr) begin
			res_row_q    <= slot_q;
			res_data_q   <= take_ok ? s_rd_q : '0;
			res_status_q <= take_ok ? ST_OK : ST_EMPTY;
		end else if (hit) begin
			res_row_q    <= row_s1;
			res_data_q   <= fv_q[row_s1] ? f_rd_q : '0;
			res_status_q <= ST_OK;
		end else if (sts.scan_miss) begin
			res_row_q    <= '0;
			res_data_q   <= '0;
			res_status_q <= ST_MISS;
		end
	end

	// occupancy: group counts registered, then summed into the result beat
	assign occ_vec = sv_q & mask_q;

	always_comb begin
		for (int g = 0; g < GRPS; g++) begin
			part_d[g] = '0;
			for (int b = 0; b < GRP; b++) begin
				part_d[g] = part_d[g] + GRP_CNT_W'(occ_vec[g * GRP + b]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.count) begin
			for (int g = 0; g < GRPS; g++) begin
				part_s1[g] <= part_d[g];
			end
		end
	end

	always_comb begin
		cnt_sum = '0;
		for (int g = 0; g < GRPS; g++) begin
			cnt_sum = cnt_sum + CNT_W'(part_s1[g]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= cmd.load || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			row_out        <= res_row_q;
			data_out       <= res_data_q;
			status         <= res_status_q;
			occupied_count <= cnt_sum;
		end
	end

	assign out_valid = out_valid_q;
endmodule
`default_nettype wire

// File: src/tag_translation_slot_table_top.sv
// Top level of the tag translation slot table.
// Usage:
//   Input channel in_valid/in_ready carries one operation per beat: kind, value_word,
//   first_word and slot. Output channel out_valid/out_ready returns one result beat
//   per operation: row_out, data_out, status and occupied_count.
//   cfg_we/cfg_wdata writes the active row count; write it only while idle.
// Sequence:
//   Insert operations: the sequencer steps through find, count and done; the result
//   is registered at done, and the next beat is accepted back in idle.
//   Take by index: the sequencer steps through read, write, count and done; the
//   result is registered at done, and the next beat is accepted back in idle.
//   Take by value reads one row per cycle from the second-word memory, in row
//   order over the active rows (active_rows capped at 64), until a hit or past the
//   last active row; with no row active it reports a miss without a row read.
//   Occupancy is counted in 8-row groups over one registered stage.
// Reset:
//   All valid marks clear, 64 rows active, no result pending.
// Stall:
//   A result waits in the output register while out_ready is low; the sequencer
//   holds in its final step and in_ready stays low until the register frees.
`timescale 1ns / 1ps
`default_nettype none
`include "tag_translation_slot_table_top_macros.svh"
module tag_translation_slot_table_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [tts_pkg::CFG_W-1:0]  cfg_wdata,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [1:0]                 kind,
	input  wire logic [tts_pkg::WORD_W-1:0] value_word,
	input  wire logic [tts_pkg::WORD_W-1:0] first_word,
	input  wire logic [tts_pkg::ROW_W-1:0]  slot,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [tts_pkg::ROW_W-1:0]       row_out,
	output logic [tts_pkg::WORD_W-1:0]      data_out,
	output logic [1:0]                      status,
	output logic [tts_pkg::CNT_W-1:0]       occupied_count
);
	import tts_pkg::*;

	tts_cmd_t cmd;
	tts_sts_t sts;

	tts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tts_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.kind           (kind),
		.value_word     (value_word),
		.first_word     (first_word),
		.slot           (slot),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.row_out        (row_out),
		.data_out       (data_out),
		.status         (status),
		.occupied_count (occupied_count)
	);

	`TTS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)
	`TTS_ASSERT_IMP(a_fail_no_data, clk, arst_n, out_valid && status != ST_OK, data_out == '0)
	`TTS_ASSERT_IMP(a_count_bound, clk, arst_n, out_valid, occupied_count <= CNT_W'(ROWS))
	`TTS_ASSERT_IMP(a_full_row_zero, clk, arst_n, out_valid && status == ST_FULL, row_out == '0)
endmodule
`default_nettype wire
